### hw/rtl/epcal_pkg.sv
// constants and month tables for the epoch seconds to calendar converter
// no dependencies; used by epoch_seconds_to_calendar

package epcal_pkg;

   // pipeline depth, input register to output register
   localparam int unsigned NUM_STAGES = 10;

   // reset value of the zone offset register
   localparam logic signed [16:0] ZONE_RESET = 17'sd28800;

   // time constants
   localparam int unsigned DAY_SECS  = 86400;
   localparam int unsigned HOUR_SECS = 3600;
   localparam int unsigned MIN_SECS  = 60;
   localparam int unsigned WEEK_DAYS = 7;
   localparam int unsigned CYC_DAYS  = 1461;   // days in a four-year cycle
   localparam int unsigned YEAR_DAYS = 365;
   localparam int unsigned YEAR_BASE = 1970;
   localparam int unsigned WEEK_BIAS = 4;      // 1970-01-01 was a thursday

   // reciprocals, floor(2^shift / divisor); estimate is low by at most one
   localparam int unsigned DAY_RECIP = 6362914;  // 2^32 / 675, input pre-shifted by 7
   localparam int unsigned CYC_RECIP = 11483;    // 2^24 / 1461
   localparam int unsigned WK_RECIP  = 149796;   // 2^20 / 7
   localparam int unsigned HR_RECIP  = 291;      // 2^20 / 3600
   localparam int unsigned MIN_RECIP = 1092;     // 2^16 / 60

   // first day of year (0 based) of each month, index 0 is january
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      logic [8:0] bump;
      begin
         bump = (leap && idx >= 4'd2) ? 9'd1 : 9'd0;
         case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
         endcase
         return base + bump;
      end
   endfunction

endpackage

### hw/rtl/epoch_seconds_to_calendar.sv
// epoch seconds to calendar date and time, ten-stage pipeline
// depends on epcal_pkg for constants and month tables
//
// Usage:
//   req_valid/req_ready carry one request: a 32-bit count of seconds since
//   1970-01-01. rsp_valid/rsp_ready return year, month, day of month,
//   week day, hour, minute and second for that request, in order.
//   csr_valid/csr_ready write the signed 17-bit zone offset, added to the
//   count before conversion with the sum wrapping at 2^32. csr_ready is
//   always high; write only while no request is in flight.
// Flow: an accepted request moves through the stage 1 to stage 10 registers
//   in order, and rsp_valid is the stage 10 valid bit. Throughput: one request
//   per cycle while rsp_ready is high, through ten register stages.
// Reset: synchronous; clears all stage valid bits and loads the zone
//   offset with 28800.
// Stall: with rsp_ready low each stage still fills while the stage after
//   it is empty, so up to ten requests are taken before req_ready drops.

module epoch_seconds_to_calendar (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [16:0] csr_zone_offset_seconds,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_epoch_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [2:0]         rsp_week_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second
);

   localparam int unsigned NS = epcal_pkg::NUM_STAGES;

   // zone offset register
   logic signed [16:0] zone_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= epcal_pkg::ZONE_RESET;
      end else if (csr_valid) begin
         zone_ff <= csr_zone_offset_seconds;
      end
   end

   // stage valid bits and advance chain
   logic [NS:1] vld_ff;
   logic [NS:1] vld_in;
   logic [NS:1] go;

   always_comb begin
      go[NS] = !vld_ff[NS] || rsp_ready;
      for (int k = NS - 1; k >= 1; k--) begin
         go[k] = !vld_ff[k] || go[k + 1];
      end
      vld_in[1] = req_valid;
      for (int k = 2; k <= NS; k++) begin
         vld_in[k] = vld_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) begin
            if (go[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   assign req_ready = go[1];
   assign rsp_valid = vld_ff[NS];

   // stage 1: add zone offset, wraps modulo 2^32
   logic [31:0] t1_ff, t1_in;

   assign t1_in = req_epoch_seconds + 32'(zone_ff);

   always_ff @(posedge clock) begin
      if (go[1]) t1_ff <= t1_in;
   end

   // stage 2: estimate day count from reciprocal
   logic [31:0] t2_ff;
   logic [15:0] d2_ff, d2_in;
   logic [47:0] day_prod;

   assign day_prod = 48'(t1_ff[31:7]) * 48'(epcal_pkg::DAY_RECIP);
   assign d2_in    = day_prod[47:32];

   always_ff @(posedge clock) begin
      if (go[2]) begin
         t2_ff <= t1_ff;
         d2_ff <= d2_in;
      end
   end

   // stage 3: remainder against estimated day count
   logic [15:0] d3_ff;
   logic [17:0] r3_ff, r3_in;
   logic [31:0] day_base;

   assign day_base = 32'(d2_ff) * 32'(epcal_pkg::DAY_SECS);
   assign r3_in    = 18'(t2_ff - day_base);

   always_ff @(posedge clock) begin
      if (go[3]) begin
         d3_ff <= d2_ff;
         r3_ff <= r3_in;
      end
   end

   // stage 4: correct day count, split seconds of day
   logic [15:0] days4_ff, days4_in;
   logic [16:0] dw4_ff, dw4_in;
   logic [16:0] sod4_ff, sod4_in;
   logic        day_wrap;

   assign day_wrap = r3_ff >= 18'(epcal_pkg::DAY_SECS);
   assign days4_in = d3_ff + 16'(day_wrap);
   assign dw4_in   = 17'(days4_in) + 17'(epcal_pkg::WEEK_BIAS);
   assign sod4_in  = day_wrap ? 17'(r3_ff - 18'(epcal_pkg::DAY_SECS)) : r3_ff[16:0];

   always_ff @(posedge clock) begin
      if (go[4]) begin
         days4_ff <= days4_in;
         dw4_ff   <= dw4_in;
         sod4_ff  <= sod4_in;
      end
   end

   // stage 5: quotient estimates for cycle, week and hour
   logic [15:0] days5_ff;
   logic [16:0] dw5_ff;
   logic [16:0] sod5_ff;
   logic [5:0]  cyc5_ff, cyc5_in;
   logic [12:0] wk5_ff, wk5_in;
   logic [5:0]  hr5_ff, hr5_in;
   logic [29:0] cyc_prod;
   logic [34:0] wk_prod;
   logic [25:0] hr_prod;

   assign cyc_prod = 30'(days4_ff) * 30'(epcal_pkg::CYC_RECIP);
   assign wk_prod  = 35'(dw4_ff) * 35'(epcal_pkg::WK_RECIP);
   assign hr_prod  = 26'(sod4_ff) * 26'(epcal_pkg::HR_RECIP);
   assign cyc5_in  = cyc_prod[29:24];
   assign wk5_in   = wk_prod[32:20];
   assign hr5_in   = hr_prod[25:20];

   always_ff @(posedge clock) begin
      if (go[5]) begin
         days5_ff <= days4_ff;
         dw5_ff   <= dw4_ff;
         sod5_ff  <= sod4_ff;
         cyc5_ff  <= cyc5_in;
         wk5_ff   <= wk5_in;
         hr5_ff   <= hr5_in;
      end
   end

   // stage 6: remainders against the estimates
   logic [5:0]  cyc6_ff;
   logic [5:0]  hr6_ff;
   logic [11:0] dic6_ff, dic6_in;
   logic [3:0]  wkr6_ff, wkr6_in;
   logic [12:0] hrr6_ff, hrr6_in;

   assign dic6_in = 12'(days5_ff - 16'(cyc5_ff) * 16'(epcal_pkg::CYC_DAYS));
   assign wkr6_in = 4'(dw5_ff - 17'(wk5_ff) * 17'(epcal_pkg::WEEK_DAYS));
   assign hrr6_in = 13'(sod5_ff - 17'(hr5_ff) * 17'(epcal_pkg::HOUR_SECS));

   always_ff @(posedge clock) begin
      if (go[6]) begin
         cyc6_ff <= cyc5_ff;
         hr6_ff  <= hr5_ff;
         dic6_ff <= dic6_in;
         wkr6_ff <= wkr6_in;
         hrr6_ff <= hrr6_in;
      end
   end

   // stage 7: one-step corrections
   logic [5:0]  cyc7_ff, cyc7_in;
   logic [10:0] dic7_ff, dic7_in;
   logic [2:0]  wk7_ff, wk7_in;
   logic [4:0]  hour7_ff, hour7_in;
   logic [11:0] soh7_ff, soh7_in;
   logic        cyc_fix, wk_fix, hr_fix;

   assign cyc_fix  = dic6_ff >= 12'(epcal_pkg::CYC_DAYS);
   assign wk_fix   = wkr6_ff >= 4'(epcal_pkg::WEEK_DAYS);
   assign hr_fix   = hrr6_ff >= 13'(epcal_pkg::HOUR_SECS);
   assign cyc7_in  = cyc6_ff + 6'(cyc_fix);
   assign dic7_in  = cyc_fix ? 11'(dic6_ff - 12'(epcal_pkg::CYC_DAYS)) : dic6_ff[10:0];
   assign wk7_in   = wk_fix ? 3'(wkr6_ff - 4'(epcal_pkg::WEEK_DAYS)) : wkr6_ff[2:0];
   assign hour7_in = 5'(hr6_ff + 6'(hr_fix));
   assign soh7_in  = hr_fix ? 12'(hrr6_ff - 13'(epcal_pkg::HOUR_SECS)) : hrr6_ff[11:0];

   always_ff @(posedge clock) begin
      if (go[7]) begin
         cyc7_ff  <= cyc7_in;
         dic7_ff  <= dic7_in;
         wk7_ff   <= wk7_in;
         hour7_ff <= hour7_in;
         soh7_ff  <= soh7_in;
      end
   end

   // stage 8: year within cycle, minute estimate
   logic [11:0] year8_ff, year8_in;
   logic [8:0]  yday8_ff, yday8_in;
   logic        leap8_ff, leap8_in;
   logic [2:0]  wk8_ff;
   logic [4:0]  hour8_ff;
   logic [11:0] soh8_ff;
   logic [5:0]  min8_ff, min8_in;
   logic [1:0]  yoff;
   logic [22:0] min_prod;

   always_comb begin
      if (dic7_ff < 11'(epcal_pkg::YEAR_DAYS)) begin
         yoff     = 2'd0;
         leap8_in = 1'b0;
         yday8_in = dic7_ff[8:0];
      end else if (dic7_ff < 11'(2 * epcal_pkg::YEAR_DAYS)) begin
         yoff     = 2'd1;
         leap8_in = 1'b0;
         yday8_in = 9'(dic7_ff - 11'(epcal_pkg::YEAR_DAYS));
      end else if (dic7_ff < 11'(3 * epcal_pkg::YEAR_DAYS + 1)) begin
         yoff     = 2'd2;
         leap8_in = 1'b1;
         yday8_in = 9'(dic7_ff - 11'(2 * epcal_pkg::YEAR_DAYS));
      end else begin
         yoff     = 2'd3;
         leap8_in = 1'b0;
         yday8_in = 9'(dic7_ff - 11'(3 * epcal_pkg::YEAR_DAYS + 1));
      end
   end

   assign year8_in = 12'(epcal_pkg::YEAR_BASE) + 12'({cyc7_ff, 2'b00}) + 12'(yoff);
   assign min_prod = 23'(soh7_ff) * 23'(epcal_pkg::MIN_RECIP);
   assign min8_in  = min_prod[21:16];

   always_ff @(posedge clock) begin
      if (go[8]) begin
         year8_ff <= year8_in;
         yday8_ff <= yday8_in;
         leap8_ff <= leap8_in;
         wk8_ff   <= wk7_ff;
         hour8_ff <= hour7_ff;
         soh8_ff  <= soh7_ff;
         min8_ff  <= min8_in;
      end
   end

   // stage 9: month search, minute remainder
   logic [11:0] year9_ff;
   logic [8:0]  yday9_ff;
   logic        leap9_ff;
   logic [2:0]  wk9_ff;
   logic [4:0]  hour9_ff;
   logic [5:0]  min9_ff;
   logic [3:0]  month9_ff, month9_in;
   logic [6:0]  minr9_ff, minr9_in;

   always_comb begin
      month9_in = 4'd1;
      for (int m = 1; m < 12; m++) begin
         if (epcal_pkg::month_start(leap8_ff, 4'(m)) <= yday8_ff) begin
            month9_in = month9_in + 4'd1;
         end
      end
   end

   assign minr9_in = 7'(soh8_ff - 12'(min8_ff) * 12'(epcal_pkg::MIN_SECS));

   always_ff @(posedge clock) begin
      if (go[9]) begin
         year9_ff  <= year8_ff;
         yday9_ff  <= yday8_ff;
         leap9_ff  <= leap8_ff;
         wk9_ff    <= wk8_ff;
         hour9_ff  <= hour8_ff;
         min9_ff   <= min8_ff;
         month9_ff <= month9_in;
         minr9_ff  <= minr9_in;
      end
   end

   // stage 10: day of month, minute correction, output register
   logic [11:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  dom_ff, dom_in;
   logic [2:0]  wk_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic        min_fix;

   assign dom_in    = 5'(yday9_ff - epcal_pkg::month_start(leap9_ff, month9_ff - 4'd1) + 9'd1);
   assign min_fix   = minr9_ff >= 7'(epcal_pkg::MIN_SECS);
   assign minute_in = min9_ff + 6'(min_fix);
   assign second_in = min_fix ? 6'(minr9_ff - 7'(epcal_pkg::MIN_SECS)) : minr9_ff[5:0];

   always_ff @(posedge clock) begin
      if (go[10]) begin
         year_ff   <= year9_ff;
         month_ff  <= month9_ff;
         dom_ff    <= dom_in;
         wk_ff     <= wk9_ff;
         hour_ff   <= hour9_ff;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = dom_ff;
   assign rsp_week_day     = wk_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;

endmodule
